FILE: hdl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared constants and types for the substring search block: default sizes,
// input action codes, the cell control bundle and the result record.
// ----------------------------------------------------------------------------
package kss_pkg;

    // Default sizes
    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 32;

    // Byte and result widths fixed by the channel layout
    localparam int BYTE_W = 8;
    localparam int OUT_POS_W = 32;

    // Input action codes
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic              clear;      // drop all partial matches
        logic              step;       // advance the chain by one text byte
        logic [BYTE_W-1:0] byte_value; // pattern byte to store or text byte
    } cell_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] position;
    } result_t;

endpackage

FILE: hdl/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell
// One cell of the matcher chain: holds one pattern byte and a flag that says
// a pattern prefix ending in this cell ends at the latest text byte.
// ----------------------------------------------------------------------------
module kss_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  kss_pkg::cell_ctrl_t     ctrl,
    input  logic                    wr_en,       // store ctrl.byte_value here
    input  logic                    prev_active, // neighbour's flag (1 for cell 0)
    output logic                    active_next, // flag for the current text byte
    output logic                    active
);

    logic [kss_pkg::BYTE_W-1:0] pattern_reg;
    logic                       active_reg;

    // Store the pattern byte when selected
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pattern_reg <= ctrl.byte_value;
        end
    end

    // Extend the neighbour's prefix when this byte matches
    always_comb begin
        if (ctrl.step) begin
            active_next = prev_active && (pattern_reg == ctrl.byte_value);
        end else begin
            active_next = active_reg;
        end
    end

    // Hold the flag; drop it when the chain is cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (ctrl.clear) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

FILE: hdl/kss_result_queue.sv
// ----------------------------------------------------------------------------
// kss_result_queue
// Two-entry output queue: lets the search side go on while a result waits
// on the master side.
// ----------------------------------------------------------------------------
module kss_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  kss_pkg::result_t  push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output kss_pkg::result_t  m_data
);

    kss_pkg::result_t slot0_reg;
    kss_pkg::result_t slot1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = slot0_reg;

    // Track occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Move payload: head first, shift on pop
    always_ff @(posedge aclk) begin
        if (pop) begin
            slot0_reg <= (push && count_reg == 2'd1) ? push_data : slot1_reg;
            if (push && count_reg == 2'd2) begin
                slot1_reg <= push_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= push_data;
            end else begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

FILE: hdl/kmp_substring_search.sv
// ----------------------------------------------------------------------------
// kmp_substring_search
// First-occurrence substring search over a byte stream, built as a chain of
// comparator cells, one per pattern byte.
//
//   Channel | Dir | tdata              | tuser      | tlast
//   s_      | in  | [7:0] byte_value   | [0] action | last
//   m_      | out | [31:0] position    | [0] found  | -
//
// One transaction is taken per cycle while s_tready is high, pattern or text
// alike; every cell compares its byte with the text byte in the same cycle
// and passes its prefix flag to the next cell. A result enters a two-entry
// queue when the text byte marked last is taken. Reset is synchronous,
// active low, and clears lengths, flags and positions. s_tready drops only
// while both queue entries hold results that the master side has not taken.
// ----------------------------------------------------------------------------
module kmp_substring_search #(
    parameter int MAX_PATTERN   = kss_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kss_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] position
    output logic        m_tuser    // [0] found
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PB    = POSITION_BITS;

    logic                 accept;
    logic                 is_text;
    logic                 queue_full;
    logic [LEN_W-1:0]     len_reg, len_next, wr_idx;
    logic                 too_long_reg, too_long_next;
    logic                 loading_reg, loading_next;
    logic [PB-1:0]        tpos_reg, tpos_next;
    logic                 seen_reg, seen_next;
    logic [PB-1:0]        mpos_reg, mpos_next;
    logic                 search_en;
    logic                 hit;
    logic [PB-1:0]        hit_pos;
    logic [31:0]          pos_out;
    logic                 seen_final;
    logic [PB-1:0]        mpos_final;
    kss_pkg::cell_ctrl_t  ctrl;
    kss_pkg::result_t     res;
    logic [MAX_PATTERN-1:0] act_next, act, wr_sel, tail_sel;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_text  = (s_tuser == kss_pkg::ACT_TEXT);

    // Pattern write slot: restart at zero when a new pattern run begins
    assign wr_idx    = loading_reg ? len_reg : '0;
    assign search_en = !seen_reg && !too_long_reg && (len_reg != '0);

    // Broadcast control to the chain; drop partial matches on a pattern byte
    // and once the text run ends
    always_comb begin
        ctrl.byte_value = s_tdata;
        ctrl.clear      = accept && (!is_text || s_tlast);
        ctrl.step       = accept && is_text && search_en;
    end

    // Cell chain
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        assign wr_sel[i]   = accept && !is_text && (wr_idx == LEN_W'(i));
        assign tail_sel[i] = (len_reg == LEN_W'(i + 1));
        kss_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .wr_en       (wr_sel[i]),
            .prev_active ((i == 0) ? 1'b1 : act[(i == 0) ? 0 : i - 1]),
            .active_next (act_next[i]),
            .active      (act[i])
        );
    end

    // Full match when the cell at the pattern's end lights up
    assign hit     = ctrl.step && |(act_next & tail_sel);
    assign hit_pos = tpos_reg + PB'(1) - PB'(len_reg);

    // Pattern load and text bookkeeping
    always_comb begin
        len_next      = len_reg;
        too_long_next = too_long_reg;
        loading_next  = loading_reg;
        tpos_next     = tpos_reg;
        seen_next     = seen_reg;
        mpos_next     = mpos_reg;
        seen_final    = seen_reg;
        mpos_final    = mpos_reg;
        if (accept) begin
            if (!is_text) begin
                tpos_next = '0;
                seen_next = 1'b0;
                mpos_next = '0;
                if (!loading_reg) begin
                    too_long_next = 1'b0;
                end
                if (wr_idx >= LEN_W'(MAX_PATTERN)) begin
                    too_long_next = 1'b1;
                    len_next      = wr_idx;
                end else begin
                    len_next = wr_idx + LEN_W'(1);
                end
                loading_next = !s_tlast;
            end else begin
                loading_next = 1'b0;
                if (hit) begin
                    seen_final = 1'b1;
                    mpos_final = hit_pos;
                end
                if (tpos_reg != '1) begin
                    tpos_next = tpos_reg + PB'(1);
                end
                seen_next = seen_final;
                mpos_next = mpos_final;
                // End of run: drop text state
                if (s_tlast) begin
                    tpos_next = '0;
                    seen_next = 1'b0;
                    mpos_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            too_long_reg <= 1'b0;
            loading_reg  <= 1'b0;
            tpos_reg     <= '0;
            seen_reg     <= 1'b0;
            mpos_reg     <= '0;
        end else begin
            len_reg      <= len_next;
            too_long_reg <= too_long_next;
            loading_reg  <= loading_next;
            tpos_reg     <= tpos_next;
            seen_reg     <= seen_next;
            mpos_reg     <= mpos_next;
        end
    end

    // Clamp the start position to the result width
    if (PB > 32) begin : g_clamp
        assign pos_out = (|mpos_final[PB-1:32]) ? '1 : mpos_final[31:0];
    end else begin : g_ext
        assign pos_out = 32'(mpos_final);
    end

    always_comb begin
        res.found    = seen_final;
        res.position = seen_final ? pos_out : '1;
    end

    kss_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && is_text && s_tlast),
        .push_data (res),
        .full      (queue_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    ({m_tuser, m_tdata})
    );

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond cell count");

    a_result_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_text && s_tlast) |=> m_tvalid)
        else $error("text run ended without a queued result");

    a_pattern_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_text) |=> (!seen_reg && (tpos_reg == '0) && (act == '0)))
        else $error("pattern byte left text state behind");

    a_text_ends_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_text) |=> !loading_reg)
        else $error("loading still open after a text byte");
`endif

endmodule
